/* rtl/core/cmi_pkg.sv */
// cmi_pkg: shared types, register indexes and built-in color map tables
// for the colormap interpolator; no dependencies
package cmi_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int MAP_BITS          = 2;
    localparam int STOP_BITS         = 3;
    localparam int MILLI_BITS        = 10;
    localparam int CHAN_BITS         = 8;

    typedef logic [CHAN_BITS-1:0]   t_chan;
    typedef logic [2:0][CHAN_BITS-1:0] t_rgb;

    typedef enum logic [1:0] {
        CFG_MAP_SELECT = 2'd0,
        CFG_RANGE_LOW  = 2'd1,
        CFG_RANGE_HIGH = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    typedef enum logic [MAP_BITS-1:0] {
        MAP_VIRIDIS = 2'd0,
        MAP_STRAT   = 2'd1,
        MAP_FLUID   = 2'd2,
        MAP_THERMAL = 2'd3
    } t_map;

    // flags that ride with an item through the fraction divider
    typedef struct packed {
        logic [MAP_BITS-1:0] map;
        logic                eq;
        logic                f_zero;
        logic                f_one;
    } t_frac_ctl;

    function automatic logic [STOP_BITS-1:0] stop_count(input logic [MAP_BITS-1:0] m);
        case (m)
            MAP_VIRIDIS: stop_count = 3'd5;
            MAP_STRAT:   stop_count = 3'd4;
            MAP_FLUID:   stop_count = 3'd3;
            default:     stop_count = 3'd4;
        endcase
    endfunction

    function automatic logic [MILLI_BITS-1:0] stop_milli(input logic [MAP_BITS-1:0] m,
                                                         input logic [STOP_BITS-1:0] i);
        stop_milli = '0;
        case (m)
            MAP_VIRIDIS: begin
                case (i)
                    3'd1:    stop_milli = 10'd250;
                    3'd2:    stop_milli = 10'd500;
                    3'd3:    stop_milli = 10'd750;
                    3'd4:    stop_milli = 10'd1000;
                    default: stop_milli = 10'd0;
                endcase
            end
            MAP_STRAT: begin
                case (i)
                    3'd1:    stop_milli = 10'd350;
                    3'd2:    stop_milli = 10'd700;
                    3'd3:    stop_milli = 10'd1000;
                    default: stop_milli = 10'd0;
                endcase
            end
            MAP_FLUID: begin
                case (i)
                    3'd1:    stop_milli = 10'd500;
                    3'd2:    stop_milli = 10'd1000;
                    default: stop_milli = 10'd0;
                endcase
            end
            default: begin
                case (i)
                    3'd1:    stop_milli = 10'd330;
                    3'd2:    stop_milli = 10'd660;
                    3'd3:    stop_milli = 10'd1000;
                    default: stop_milli = 10'd0;
                endcase
            end
        endcase
    endfunction

    function automatic t_rgb stop_color(input logic [MAP_BITS-1:0] m,
                                        input logic [STOP_BITS-1:0] i);
        stop_color = '0;
        case (m)
            MAP_VIRIDIS: begin
                case (i)
                    3'd0:    stop_color = {8'd84,  8'd1,   8'd68};
                    3'd1:    stop_color = {8'd139, 8'd82,  8'd59};
                    3'd2:    stop_color = {8'd140, 8'd145, 8'd33};
                    3'd3:    stop_color = {8'd98,  8'd201, 8'd94};
                    3'd4:    stop_color = {8'd37,  8'd231, 8'd253};
                    default: stop_color = '0;
                endcase
            end
            MAP_STRAT: begin
                case (i)
                    3'd0:    stop_color = {8'd120, 8'd110, 8'd100};
                    3'd1:    stop_color = {8'd155, 8'd175, 8'd160};
                    3'd2:    stop_color = {8'd95,  8'd220, 8'd255};
                    3'd3:    stop_color = {8'd255, 8'd175, 8'd90};
                    default: stop_color = '0;
                endcase
            end
            MAP_FLUID: begin
                case (i)
                    3'd0:    stop_color = {8'd255, 8'd115, 8'd40};
                    3'd1:    stop_color = {8'd100, 8'd220, 8'd50};
                    3'd2:    stop_color = {8'd55,  8'd55,  8'd255};
                    default: stop_color = '0;
                endcase
            end
            default: begin
                case (i)
                    3'd0:    stop_color = {8'd150, 8'd0,   8'd0};
                    3'd1:    stop_color = {8'd200, 8'd200, 8'd0};
                    3'd2:    stop_color = {8'd0,   8'd220, 8'd220};
                    3'd3:    stop_color = {8'd0,   8'd0,   8'd255};
                    default: stop_color = '0;
                endcase
            end
        endcase
    endfunction

endpackage

/* rtl/core/colormap_interpolator.sv */
// colormap_interpolator: sample to RGB through a piecewise-linear color map
// throughput: one item per clock, busy is always low; the fraction divider
// (FRACTION_BITS + 1 stages) and the channel dividers (9 stages) set latency
// synchronous active-low reset clears the pipeline valid bits and sets the
// registers to viridis, range 0 to 32767
module colormap_interpolator #(
    parameter int SAMPLE_BITS   = cmi_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = cmi_pkg::FRACTION_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_value,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [SAMPLE_BITS-1:0] i_cfg_data,
    output logic                   o_valid,
    output logic [cmi_pkg::CHAN_BITS-1:0] o_red,
    output logic [cmi_pkg::CHAN_BITS-1:0] o_green,
    output logic [cmi_pkg::CHAN_BITS-1:0] o_blue
);
    import cmi_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int FB = FRACTION_BITS;
    localparam int FW = FB + 1;          // fraction, one included
    localparam int XW = FB + 1 + CHAN_BITS;

    function automatic logic [FW-1:0] stop_pos(input logic [MILLI_BITS-1:0] milli);
        logic [FB+MILLI_BITS:0] t;
        t = ((FB+MILLI_BITS+1)'(milli) << FB) + (FB+MILLI_BITS+1)'(500);
        stop_pos = FW'(t / 1000);
    endfunction

    // stop position table, every map folded to constants before the select
    function automatic logic [FW-1:0] seg_pos(input logic [MAP_BITS-1:0] m,
                                              input logic [STOP_BITS-1:0] i);
        case (m)
            MAP_VIRIDIS: seg_pos = stop_pos(stop_milli(MAP_VIRIDIS, i));
            MAP_STRAT:   seg_pos = stop_pos(stop_milli(MAP_STRAT, i));
            MAP_FLUID:   seg_pos = stop_pos(stop_milli(MAP_FLUID, i));
            default:     seg_pos = stop_pos(stop_milli(MAP_THERMAL, i));
        endcase
    endfunction

    // configuration registers
    logic [MAP_BITS-1:0] r_map;
    logic signed [SB-1:0] r_low, r_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map  <= MAP_VIRIDIS;
            r_low  <= '0;
            r_high <= SB'(32767);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MAP_SELECT: r_map  <= i_cfg_data[MAP_BITS-1:0];
                CFG_RANGE_LOW:  r_low  <= i_cfg_data;
                CFG_RANGE_HIGH: r_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // front end: signed ratio set-up
    logic signed [SB:0] num, den;
    logic [SB-1:0] an, ad;
    logic neg;
    t_frac_ctl in_ctl;

    always_comb begin
        num = SB'(0) + ($signed({i_sample_value[SB-1], i_sample_value}) -
                        $signed({r_low[SB-1], r_low}));
        den = $signed({r_high[SB-1], r_high}) - $signed({r_low[SB-1], r_low});
        neg = num[SB] != den[SB];
        an  = num[SB] ? SB'(-num) : SB'(num);
        ad  = den[SB] ? SB'(-den) : SB'(den);
        in_ctl.map    = r_map;
        in_ctl.eq     = den == '0;
        in_ctl.f_zero = (num != '0) && neg;
        in_ctl.f_one  = an >= ad;
    end

    logic          fd_valid;
    logic [FB-1:0] fd_quot;
    t_frac_ctl     fd_ctl;

    cmi_div_pipe #(
        .NUM_W(SB + FB), .DEN_W(SB), .QB(FB), .SIDE_W($bits(t_frac_ctl))
    ) u_frac_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_num   ({an, FB'(0)}),
        .i_den   (ad),
        .i_side  (in_ctl),
        .o_valid (fd_valid),
        .o_quot  (fd_quot),
        .o_side  (fd_ctl)
    );

    // segment search
    logic [FW-1:0] f, t1, t2, n_delta, n_rng;
    t_rgb          n_c1, n_c2;
    logic          found;

    always_comb begin
        if (fd_ctl.f_zero) begin
            f = '0;
        end else if (fd_ctl.f_one) begin
            f = FW'(1) << FB;
        end else begin
            f = {1'b0, fd_quot};
        end
        found   = 1'b0;
        n_c1    = stop_color(fd_ctl.map, stop_count(fd_ctl.map) - 3'd1);
        n_c2    = n_c1;
        n_delta = '0;
        n_rng   = FW'(1);
        t1      = '0;
        t2      = '0;
        for (int i = 0; i < 4; i++) begin
            if (!found && (3'(i + 1) < stop_count(fd_ctl.map))) begin
                t1 = seg_pos(fd_ctl.map, 3'(i));
                t2 = seg_pos(fd_ctl.map, 3'(i + 1));
                if (t1 <= f && f <= t2) begin
                    found   = 1'b1;
                    n_c1    = stop_color(fd_ctl.map, 3'(i));
                    n_c2    = stop_color(fd_ctl.map, 3'(i + 1));
                    n_delta = f - t1;
                    n_rng   = t2 - t1;
                end
            end
        end
        // zero-width segment or equal bounds: hold the first color
        if (n_rng == '0) begin
            n_c2    = n_c1;
            n_delta = '0;
            n_rng   = FW'(1);
        end
        if (fd_ctl.eq) begin
            n_c1    = stop_color(fd_ctl.map, 3'd0);
            n_c2    = n_c1;
            n_delta = '0;
            n_rng   = FW'(1);
        end
    end

    logic          r_s1_valid;
    t_rgb          r_s1_c1, r_s1_d;
    logic [2:0]    r_s1_down;
    logic [FW-1:0] r_s1_delta, r_s1_rng;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= fd_valid;
        end
        r_s1_c1    <= n_c1;
        r_s1_delta <= n_delta;
        r_s1_rng   <= n_rng;
        for (int c = 0; c < 3; c++) begin
            r_s1_down[c] <= n_c2[c] < n_c1[c];
            r_s1_d[c]    <= (n_c2[c] < n_c1[c]) ? n_c1[c] - n_c2[c] : n_c2[c] - n_c1[c];
        end
    end

    // scaled step per channel; downward steps round up
    logic          r_s2_valid;
    t_rgb          r_s2_c1;
    logic [2:0]    r_s2_down;
    logic [FW-1:0] r_s2_rng;
    logic [XW-1:0] r_s2_x [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_c1   <= r_s1_c1;
        r_s2_down <= r_s1_down;
        r_s2_rng  <= r_s1_rng;
        for (int c = 0; c < 3; c++) begin
            r_s2_x[c] <= XW'(r_s1_delta) * XW'(r_s1_d[c]) +
                         (r_s1_down[c] ? XW'(r_s1_rng - FW'(1)) : XW'(0));
        end
    end

    logic [2:0]             cd_valid;
    logic [CHAN_BITS-1:0]   cd_quot [0:2];
    logic [CHAN_BITS:0]     cd_side [0:2];

    for (genvar c = 0; c < 3; c++) begin : g_chan
        cmi_div_pipe #(
            .NUM_W(XW), .DEN_W(FW), .QB(CHAN_BITS), .SIDE_W(CHAN_BITS + 1)
        ) u_chan_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_s2_valid),
            .i_num   (r_s2_x[c]),
            .i_den   (r_s2_rng),
            .i_side  ({r_s2_down[c], r_s2_c1[c]}),
            .o_valid (cd_valid[c]),
            .o_quot  (cd_quot[c]),
            .o_side  (cd_side[c])
        );
    end

    logic r_out_valid;
    t_rgb r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= &cd_valid;
        end
        for (int c = 0; c < 3; c++) begin
            r_out[c] <= cd_side[c][CHAN_BITS] ? cd_side[c][CHAN_BITS-1:0] - cd_quot[c]
                                              : cd_side[c][CHAN_BITS-1:0] + cd_quot[c];
        end
    end

    assign o_valid = r_out_valid;
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];
endmodule

/* rtl/core/cmi_div_pipe.sv */
// cmi_div_pipe: pipelined restoring divider, one quotient bit per stage
// depends on nothing; the quotient must fit in QB bits
module cmi_div_pipe #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int QB     = 16,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QB-1:0]     o_quot,
    output logic [SIDE_W-1:0] o_side
);
    localparam int W = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;

    logic              r_valid [0:QB];
    logic [W-1:0]      r_rem   [0:QB];
    logic [DEN_W-1:0]  r_den   [0:QB];
    logic [QB-1:0]     r_quot  [0:QB];
    logic [SIDE_W-1:0] r_side  [0:QB];

    logic [W-1:0]      n_rem   [0:QB-1];
    logic [QB-1:0]     n_quot  [0:QB-1];

    always_comb begin : p_stage
        logic [W-1:0] shifted;
        logic         ge;
        for (int k = 0; k < QB; k++) begin
            shifted   = W'(r_den[k]) << (QB - 1 - k);
            ge        = r_rem[k] >= shifted;
            n_rem[k]  = ge ? r_rem[k] - shifted : r_rem[k];
            n_quot[k] = r_quot[k];
            n_quot[k][QB-1-k] = ge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QB; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            r_valid[0] <= i_valid;
            for (int k = 0; k < QB; k++) begin
                r_valid[k+1] <= r_valid[k];
            end
        end
        r_rem[0]  <= W'(i_num);
        r_den[0]  <= i_den;
        r_quot[0] <= '0;
        r_side[0] <= i_side;
        for (int k = 0; k < QB; k++) begin
            r_rem[k+1]  <= n_rem[k];
            r_den[k+1]  <= r_den[k];
            r_quot[k+1] <= n_quot[k];
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_valid[QB];
    assign o_quot  = r_quot[QB];
    assign o_side  = r_side[QB];
endmodule
